>>> src/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types for the i2c master bit engine: command codes, sequencer
// phases and the sequencer state record.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned BitsPerByte = 8;

  localparam logic [CntW-1:0] HalfPeriodRst = 16'd1;
  localparam logic [CntW-1:0] AckTimeoutRst = 16'd1000;

  // configuration register indexes
  typedef enum logic {
    CFG_HALF_PERIOD = 1'b0,
    CFG_ACK_TIMEOUT = 1'b1
  } cfg_idx_e;

  // command codes carried by each tick transaction
  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_START     = 3'd1,
    MODE_STOP      = 3'd2,
    MODE_WRITE     = 3'd3,
    MODE_READ_ACK  = 3'd4,
    MODE_READ_NACK = 3'd5
  } mode_e;

  // bus sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_S1    = 5'd1,
    PH_S2    = 5'd2,
    PH_S3    = 5'd3,
    PH_P1    = 5'd4,
    PH_P2    = 5'd5,
    PH_P3    = 5'd6,
    PH_WDATA = 5'd7,
    PH_WHI   = 5'd8,
    PH_WLO   = 5'd9,
    PH_WREL  = 5'd10,
    PH_POLL  = 5'd11,
    PH_AHI   = 5'd12,
    PH_ALO   = 5'd13,
    PH_RREL  = 5'd14,
    PH_RLO   = 5'd15,
    PH_RHI   = 5'd16,
    PH_KLO   = 5'd17,
    PH_KSDA  = 5'd18,
    PH_KHI   = 5'd19,
    PH_KLO2  = 5'd20
  } phase_e;

  // complete sequencer state
  typedef struct packed {
    phase_e              phase;
    logic [2:0]          operation;
    logic [BitCntW-1:0]  bit_count;
    logic [ByteW-1:0]    shift_data;
    logic [CntW-1:0]     delay_count;
    logic [CntW-1:0]     wait_count;
    logic                scl_drive;
    logic                sda_drive;
    logic                ack_flag;
    logic [ByteW-1:0]    rx_hold;
  } seq_state_t;

endpackage

>>> src/i2cmbe_step.sv
// ----------------------------------------------------------------------------
// i2cmbe_step
// One time step of the bus sequencer: next state and done flag from the
// current state, the tick transaction and the configuration registers.
// ----------------------------------------------------------------------------
module i2cmbe_step (
  input  i2cmbe_pkg::seq_state_t  st_i,
  input  logic [2:0]              mode_i,
  input  logic [7:0]              tx_byte_i,
  input  logic                    sda_in_i,
  input  logic [15:0]             half_period_i,
  input  logic [15:0]             ack_timeout_i,
  output i2cmbe_pkg::seq_state_t  st_o,
  output logic                    done_o
);
  import i2cmbe_pkg::*;

  // enter a phase: reload the delay and apply the line change of that phase
  function automatic seq_state_t enter_phase(seq_state_t s, phase_e p,
                                             logic [CntW-1:0] hp);
    seq_state_t r;
    r = s;
    r.phase = p;
    r.delay_count = (hp == '0) ? CntW'(1) : hp;
    unique case (p)
      PH_S1: begin
        r.scl_drive = 1'b1;
        r.sda_drive = 1'b1;
      end
      PH_S2:    r.sda_drive = 1'b0;
      PH_S3:    r.scl_drive = 1'b0;
      PH_P1: begin
        r.scl_drive = 1'b0;
        r.sda_drive = 1'b0;
      end
      PH_P2:    r.scl_drive = 1'b1;
      PH_P3:    r.sda_drive = 1'b1;
      PH_WDATA: begin
        r.sda_drive  = s.shift_data[ByteW-1];
        r.shift_data = {s.shift_data[ByteW-2:0], 1'b0};
      end
      PH_WHI:   r.scl_drive = 1'b1;
      PH_WLO:   r.scl_drive = 1'b0;
      PH_WREL:  r.sda_drive = 1'b1;
      PH_POLL: begin
        r.wait_count  = '0;
        r.delay_count = '0;
      end
      PH_AHI:   r.scl_drive = 1'b1;
      PH_ALO:   r.scl_drive = 1'b0;
      PH_RREL:  r.sda_drive = 1'b1;
      PH_RLO:   r.scl_drive = 1'b0;
      PH_RHI:   r.scl_drive = 1'b1;
      PH_KLO:   r.scl_drive = 1'b0;
      PH_KSDA:  r.sda_drive = (s.operation != 3'(MODE_READ_ACK));
      PH_KHI:   r.scl_drive = 1'b1;
      PH_KLO2:  r.scl_drive = 1'b0;
      default: ;
    endcase
    return r;
  endfunction

  seq_state_t st;
  phase_e     nxt;
  logic       fin;

  always_comb begin
    st     = st_i;
    nxt    = PH_IDLE;
    fin    = 1'b0;
    done_o = 1'b0;
    unique case (st_i.phase)
      // idle: take a command
      PH_IDLE: begin
        unique case (mode_i)
          MODE_START: begin
            st.operation = mode_i;
            st.bit_count = '0;
            st = enter_phase(st, PH_S1, half_period_i);
          end
          MODE_STOP: begin
            st.operation = mode_i;
            st.bit_count = '0;
            st = enter_phase(st, PH_P1, half_period_i);
          end
          MODE_WRITE: begin
            st.operation  = mode_i;
            st.bit_count  = '0;
            st.shift_data = tx_byte_i;
            st = enter_phase(st, PH_WDATA, half_period_i);
          end
          MODE_READ_ACK, MODE_READ_NACK: begin
            st.operation  = mode_i;
            st.bit_count  = '0;
            st.shift_data = '0;
            st = enter_phase(st, PH_RREL, half_period_i);
          end
          default: ;
        endcase
      end
      // acknowledge wait with timeout into a stop
      PH_POLL: begin
        if (!sda_in_i) begin
          st.ack_flag = 1'b1;
          st = enter_phase(st, PH_AHI, half_period_i);
        end else if (st_i.wait_count >= ack_timeout_i) begin
          st.ack_flag  = 1'b0;
          st.operation = 3'(MODE_STOP);
          st = enter_phase(st, PH_P1, half_period_i);
        end else begin
          st.wait_count = st_i.wait_count + CntW'(1);
        end
      end
      // timed phases: count down, then advance to the next phase or finish
      default: begin
        if (st.delay_count != '0) begin
          st.delay_count = st.delay_count - CntW'(1);
        end
        if (st.delay_count == '0) begin
          unique case (st_i.phase)
            PH_S1:    nxt = PH_S2;
            PH_S2:    nxt = PH_S3;
            PH_P1:    nxt = PH_P2;
            PH_P2:    nxt = PH_P3;
            PH_WDATA: nxt = PH_WHI;
            PH_WHI:   nxt = PH_WLO;
            PH_WLO: begin
              st.bit_count = st.bit_count + BitCntW'(1);
              nxt = (st.bit_count < BitCntW'(BitsPerByte)) ? PH_WDATA : PH_WREL;
            end
            PH_WREL:  nxt = PH_POLL;
            PH_AHI:   nxt = PH_ALO;
            PH_RREL:  nxt = PH_RLO;
            PH_RLO:   nxt = PH_RHI;
            PH_RHI: begin
              st.shift_data = {st.shift_data[ByteW-2:0], sda_in_i};
              st.bit_count  = st.bit_count + BitCntW'(1);
              if (st.bit_count < BitCntW'(BitsPerByte)) begin
                nxt = PH_RLO;
              end else begin
                st.rx_hold = st.shift_data;
                nxt = PH_KLO;
              end
            end
            PH_KLO:   nxt = PH_KSDA;
            PH_KSDA:  nxt = PH_KHI;
            PH_KHI:   nxt = PH_KLO2;
            default:  fin = 1'b1;
          endcase
          if (fin) begin
            st.phase = PH_IDLE;
            done_o   = 1'b1;
          end else begin
            st = enter_phase(st, nxt, half_period_i);
          end
        end
      end
    endcase
    st_o = st;
  end

endmodule

>>> src/i2c_master_bit_engine_top.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_top
// I2C master bit engine: one tick transaction in, one line/status result out.
// ----------------------------------------------------------------------------
// Each input transaction is one bus tick: the sequencer state register is
// updated by a single step of combinational logic and the result lands in an
// output register, so a new transaction is accepted every cycle while the
// output register is free or being drained.
// Commands (start, stop, write, read with ack/nack) are taken only when the
// sequencer is idle; every line change is held for half_period ticks and the
// acknowledge wait gives up after ack_timeout ticks of SDA high, issuing a
// stop and clearing ack_ok. Configuration writes take effect at once and
// should be made while the engine is idle.
module i2c_master_bit_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // tick input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [7:0] tx_byte, [8] sda_in, [15:9] zero
  input  logic [15:0] s_axis_tdata,
  // tuser: [2:0] mode
  input  logic [2:0]  s_axis_tuser,
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
  //        [11:4] rx_byte, [12] ack_ok, [15:13] zero
  output logic [15:0] m_axis_tdata
);
  import i2cmbe_pkg::*;

  logic [CntW-1:0] half_period_q;
  logic [CntW-1:0] ack_timeout_q;
  seq_state_t      st_q, st_d;
  logic            done;
  logic            accept;
  logic            out_valid_q;
  logic [15:0]     out_data_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodRst;
      ack_timeout_q <= AckTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HALF_PERIOD: half_period_q <= cfg_wdata_i;
        CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // sequencer step
  i2cmbe_step u_step (
    .st_i          (st_q),
    .mode_i        (s_axis_tuser),
    .tx_byte_i     (s_axis_tdata[7:0]),
    .sda_in_i      (s_axis_tdata[8]),
    .half_period_i (half_period_q),
    .ack_timeout_i (ack_timeout_q),
    .st_o          (st_d),
    .done_o        (done)
  );

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase       <= PH_IDLE;
      st_q.operation   <= '0;
      st_q.bit_count   <= '0;
      st_q.shift_data  <= '0;
      st_q.delay_count <= '0;
      st_q.wait_count  <= '0;
      st_q.scl_drive   <= 1'b1;
      st_q.sda_drive   <= 1'b1;
      st_q.ack_flag    <= 1'b0;
      st_q.rx_hold     <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {3'b000, st_d.ack_flag, st_d.rx_hold, done,
                     (st_d.phase != PH_IDLE), st_d.sda_drive, st_d.scl_drive};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
